// ----- hw/rtl/a85_pkg.sv -----
package a85_pkg;

	localparam logic [7:0] CH_ZERO_GROUP = 8'h7A;
	localparam logic [7:0] CH_LOW        = 8'h21;
	localparam logic [7:0] CH_HIGH       = 8'h75;
	localparam logic [2:0] GROUP_LAST    = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	typedef struct packed {
		logic [2:0]  group_pos;
		logic [31:0] accum;
		logic        error_hold;
	} dec_state_t;

	typedef struct packed {
		logic        emit;
		logic [31:0] word;
		logic [1:0]  status;
		logic        done_res;
	} dec_result_t;

endpackage

// ----- hw/rtl/a85_step.sv -----
module a85_step (
	input  logic [7:0]           ch,
	input  logic                 last,
	input  a85_pkg::dec_state_t  cur,
	output a85_pkg::dec_state_t  nxt,
	output a85_pkg::dec_result_t res
);

	logic [7:0]  digit;
	logic [31:0] acc_mul;
	logic [31:0] acc_new;
	logic        out_of_range;

	assign digit        = ch - a85_pkg::CH_LOW;
	assign out_of_range = (ch < a85_pkg::CH_LOW) || (ch > a85_pkg::CH_HIGH);
	// Multiply by 85 as 64 + 16 + 4 + 1, wrapping at 32 bits.
	assign acc_mul = (cur.accum << 6) + (cur.accum << 4) + (cur.accum << 2) + cur.accum;
	assign acc_new = acc_mul + {24'd0, digit};

	always_comb begin
		nxt = cur;
		res = '{emit: 1'b0, word: 32'd0, status: a85_pkg::ST_OK, done_res: 1'b0};
		priority if (cur.error_hold) begin
			if (last) begin
				nxt = '0;
			end
		end else if (cur.group_pos == 3'd0 && ch == a85_pkg::CH_ZERO_GROUP) begin
			nxt          = '0;
			res.emit     = 1'b1;
			res.done_res = last;
		end else if (out_of_range) begin
			nxt            = '0;
			nxt.error_hold = ~last;
			res.emit       = 1'b1;
			res.status     = a85_pkg::ST_INVALID;
			res.done_res   = 1'b1;
		end else if (cur.group_pos == a85_pkg::GROUP_LAST) begin
			nxt          = '0;
			res.emit     = 1'b1;
			res.word     = acc_new;
			res.done_res = last;
		end else if (last) begin
			nxt          = '0;
			res.emit     = 1'b1;
			res.status   = a85_pkg::ST_TRUNCATED;
			res.done_res = 1'b1;
		end else begin
			nxt.group_pos = cur.group_pos + 3'd1;
			nxt.accum     = acc_new;
		end
	end

endmodule

// ----- hw/rtl/ascii85_stream_decoder.sv -----
// Ascii85 decoder taking one character item per cycle when in_stall is low,
// with a last flag on the final character of a string. Each complete
// five-character group, or a 'z' at a group start, produces one 32-bit word
// item, first byte in bits 31..24. A character outside '!'..'u' produces one
// invalid-status item and the rest of the string is dropped; a string ending
// inside a group produces one truncated-status item. The block sustains one
// item per cycle while the output is not stalled; an item passes an input
// register and then a result register. The input register holds one more item
// behind the result register; a stalled output holds the input side after it.
module ascii85_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] word,
	output logic [1:0]  status,
	output logic        done_res
);

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 last_s1;
	logic                 advance;
	a85_pkg::dec_state_t  state_q;
	a85_pkg::dec_state_t  state_nxt;
	a85_pkg::dec_result_t res;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	a85_step u_step (
		.ch   (ch_s1),
		.last (last_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res.emit;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			word     <= res.word;
			status   <= res.status;
			done_res <= res.done_res;
		end
	end

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == a85_pkg::ST_OK || status == a85_pkg::ST_INVALID ||
			status == a85_pkg::ST_TRUNCATED))
		else $error("Result item carries an unknown status code.");

	a_error_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != a85_pkg::ST_OK) |-> (word == 32'd0 && done_res))
		else $error("Error item must carry a zero word and end the string.");

	a_group_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.group_pos <= a85_pkg::GROUP_LAST)
		else $error("Group position ran past the fifth character.");

	a_hold_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.error_hold |-> (state_q.group_pos == 3'd0 && state_q.accum == 32'd0))
		else $error("Group not cleared while characters are dropped.");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("Input stalled without a blocked result.");

endmodule
